// ----- hdl/utf8_code_point_decoder_core_assert.svh -----
// Assertion macros used by the decoder's checker file.
`ifndef UTF8_CODE_POINT_DECODER_CORE_ASSERT_SVH
`define UTF8_CODE_POINT_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define U8CPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define U8CPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/u8cpd_pkg.sv -----
// Types and constants shared by the UTF-8 code point decoder modules.
`default_nettype none

package u8cpd_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OutDataW = 24;

  // Replacement character emitted for malformed input.
  localparam logic [CpW-1:0] ReplCp = 21'h00FFFD;

  // Continuation bytes still expected by an open sequence.
  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendOne   = 2'd1;
  localparam logic [1:0] PendTwo   = 2'd2;
  localparam logic [1:0] PendThree = 2'd3;

  // One queue entry: the results caused by one input byte.
  // With two set, a replacement precedes the result held in cp and rep.
  typedef struct packed {
    logic           fin;
    logic           two;
    logic           rep;
    logic [CpW-1:0] cp;
  } u8cpd_entry_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } u8cpd_qstat_t;

endpackage

`default_nettype wire

// ----- hdl/u8cpd_front.sv -----
// Front part: accepts bytes, tracks the open sequence and forms queue entries.
`default_nettype none

module u8cpd_front
  import u8cpd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic             fin_i,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire u8cpd_qstat_t     qstat_i,
  output logic                  push_o,
  output u8cpd_entry_t          entry_o
);

  logic [1:0]     pend_q, pend_d;
  logic [CpW-1:0] part_q, part_d;

  logic           idle_has, idle_rep;
  logic [CpW-1:0] idle_cp, idle_part;
  logic [1:0]     idle_pend;
  logic           is_cont;
  logic [CpW-1:0] shifted;

  assign ready_o = !qstat_i.full;
  assign is_cont = (byte_i[7:6] == 2'b10);
  assign shifted = {part_q[CpW-7:0], byte_i[5:0]};

  // Decode of a byte as if no sequence were open.
  always_comb begin
    idle_has  = 1'b1;
    idle_rep  = 1'b1;
    idle_cp   = ReplCp;
    idle_pend = PendNone;
    idle_part = '0;
    if (!byte_i[7]) begin
      idle_rep = 1'b0;
      idle_cp  = {{(CpW-ByteW){1'b0}}, byte_i};
    end else if (byte_i[7:5] == 3'b110) begin
      idle_pend = PendOne;
      idle_part = {{(CpW-5){1'b0}}, byte_i[4:0]};
    end else if (byte_i[7:4] == 4'b1110) begin
      idle_pend = PendTwo;
      idle_part = {{(CpW-4){1'b0}}, byte_i[3:0]};
    end else if (byte_i[7:3] == 5'b11110) begin
      idle_pend = PendThree;
      idle_part = {{(CpW-3){1'b0}}, byte_i[2:0]};
    end
    // A lead byte that is not cut off waits for continuation bytes.
    if (idle_pend != PendNone) begin
      idle_has = fin_i;
    end
  end

  // Next sequence state and the entry for this byte.
  always_comb begin
    pend_d        = pend_q;
    part_d        = part_q;
    push_o        = 1'b0;
    entry_o.fin   = fin_i;
    entry_o.two   = 1'b0;
    entry_o.rep   = 1'b1;
    entry_o.cp    = ReplCp;
    if (pend_q == PendNone) begin
      pend_d      = idle_pend;
      part_d      = idle_part;
      push_o      = idle_has;
      entry_o.rep = idle_rep;
      entry_o.cp  = idle_cp;
    end else if (is_cont) begin
      pend_d = pend_q - 2'd1;
      part_d = shifted;
      if (pend_q == PendOne) begin
        part_d      = '0;
        push_o      = 1'b1;
        entry_o.rep = 1'b0;
        entry_o.cp  = shifted;
      end else begin
        push_o = fin_i;
      end
    end else begin
      // Broken sequence: a replacement, then the byte decoded afresh.
      pend_d = idle_pend;
      part_d = idle_part;
      push_o = 1'b1;
      if (idle_has) begin
        entry_o.two = 1'b1;
        entry_o.rep = idle_rep;
        entry_o.cp  = idle_cp;
      end
    end
    if (fin_i) begin
      pend_d = PendNone;
      part_d = '0;
    end
    push_o = push_o && valid_i && ready_o;
  end

  // Sequence state advances on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PendNone;
      part_q <= '0;
    end else if (valid_i && ready_o) begin
      pend_q <= pend_d;
      part_q <= part_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/u8cpd_fifo.sv -----
// Short queue of decoded entries between the front and back parts.
`default_nettype none

module u8cpd_fifo
  import u8cpd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire u8cpd_entry_t entry_i,
  input  wire logic         pop_i,
  output u8cpd_entry_t      head_o,
  output u8cpd_qstat_t      qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u8cpd_entry_t      mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == FullCnt);
  assign qstat_o.empty = (cnt_q == '0);

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/u8cpd_back.sv -----
// Back part: expands queue entries into result beats through an output register.
`default_nettype none

module u8cpd_back
  import u8cpd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire u8cpd_entry_t head_i,
  input  wire u8cpd_qstat_t qstat_i,
  output logic              pop_o,
  output logic              valid_o,
  input  wire logic         ready_i,
  output logic [CpW-1:0]    cp_o,
  output logic              rep_o,
  output logic              run_end_o,
  output logic              text_end_o
);

  logic valid_q, valid_d;
  logic phase_q, phase_d;
  logic load;
  logic first_half;

  assign valid_o    = valid_q;
  assign load       = !valid_q || ready_i;
  assign first_half = head_i.two && !phase_q;
  assign pop_o      = load && !qstat_i.empty && !first_half;

  // Output register control.
  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (load) begin
      valid_d = !qstat_i.empty;
      if (!qstat_i.empty) begin
        phase_d = first_half;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // Result payload: the leading replacement of a two-result entry, or its final result.
  always_ff @(posedge clk_i) begin
    if (load && !qstat_i.empty) begin
      if (first_half) begin
        cp_o       <= ReplCp;
        rep_o      <= 1'b1;
        run_end_o  <= 1'b0;
        text_end_o <= 1'b0;
      end else begin
        cp_o       <= head_i.cp;
        rep_o      <= head_i.rep;
        run_end_o  <= 1'b1;
        text_end_o <= head_i.fin;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/utf8_code_point_decoder_core.sv -----
// Top level of the streaming UTF-8 code point decoder.
//
//   Channel   Direction  tdata              tuser                 tlast
//   s_axis    in         data_byte[7:0]     none                  final_byte
//   m_axis    out        code_point[20:0]   replaced, run_end     text_end
//
// One byte is accepted per cycle while the entry queue has room.
// A byte yielding one result gives one beat at m_axis; a broken sequence whose
// byte also yields a result of its own gives two results, as two beats at m_axis.
// An accepted byte's results pass through the entry queue, then the output register.
// Reset clears the sequence state, the queue and the output valid flag.
// Output stalls fill the queue, after which s_axis_tready drops.
`default_nettype none

module utf8_code_point_decoder_core
  import u8cpd_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  wire logic                s_axis_tlast,   // final_byte
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]               m_axis_tuser,   // [0] replaced, [1] run_end
  output logic                     m_axis_tlast    // text_end
);

  u8cpd_qstat_t   qstat;
  u8cpd_entry_t   push_entry, head;
  logic           push, pop;
  logic [CpW-1:0] cp;

  u8cpd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (s_axis_tdata),
    .fin_i   (s_axis_tlast),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  u8cpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  u8cpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .cp_o       (cp),
    .rep_o      (m_axis_tuser[0]),
    .run_end_o  (m_axis_tuser[1]),
    .text_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OutDataW-CpW){1'b0}}, cp};

endmodule

`default_nettype wire

// ----- hdl/u8cpd_checker.sv -----
// Port-level checker for the UTF-8 code point decoder, bound to the top level.
`default_nettype none

`include "utf8_code_point_decoder_core_assert.svh"

module u8cpd_checker
  import u8cpd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic [1:0]          m_axis_tuser,
  input wire logic                m_axis_tlast
);

  logic                stall;
  logic                vld_last;
  logic                vld_rep;
  logic                vld_open;
  logic                rep_only;
  logic [OutDataW+2:0] beat;

  // Shorthand for the result channel's state in the current cycle.
  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign vld_last = m_axis_tvalid && m_axis_tlast;
  assign vld_rep  = m_axis_tvalid && m_axis_tuser[0];
  assign vld_open = m_axis_tvalid && !m_axis_tuser[1];
  assign rep_only = m_axis_tuser[0] && !m_axis_tlast;
  assign beat     = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // A stalled result beat keeps its contents.
  `U8CPD_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(beat), "stalled beat changed")

  // The end of the text is also the end of that byte's results.
  `U8CPD_ASSERT_NOW(a_text_end_run, vld_last, m_axis_tuser[1], "text_end without run_end")

  // A replacement always carries U+FFFD.
  `U8CPD_ASSERT_NOW(a_repl_value, vld_rep, m_axis_tdata == 24'h00FFFD, "wrong replacement value")

  // Only a leading replacement can leave a byte's results open.
  `U8CPD_ASSERT_NOW(a_open_is_repl, vld_open, rep_only, "open beat is not a replacement")

endmodule

bind utf8_code_point_decoder_core u8cpd_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the streaming UTF-8 code point decoder.
`timescale 1ns / 1ps

module tb
  import u8cpd_pkg::*;
();

  localparam int unsigned RandomBytes = 1200;
  localparam int unsigned GapPercent  = 32;
  localparam int unsigned HoldAt      = 350;
  localparam int unsigned HoldCycles  = 100;
  localparam int unsigned DrainAt     = 850;
  localparam int unsigned QuietFrom   = 500;
  localparam int unsigned QuietTo     = 700;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned StuckLimit  = 4000;
  localparam int unsigned ShownErrors = 10;

  // One expected output beat.
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           rep;
    logic           run_end;
    logic           text_end;
  } cp_beat_t;

  // Tracks the decoder state and holds the code points still owed by the block.
  class utf8_scoreboard;
    cp_beat_t       expected_q[$];
    cp_beat_t       fresh_q[$];
    logic [1:0]     pending;
    logic [CpW-1:0] partial;
    int unsigned    mismatches;

    function new();
      pending    = PendNone;
      partial    = '0;
      mismatches = 0;
    endfunction

    function void emit(logic [CpW-1:0] cp, logic rep);
      cp_beat_t beat;
      beat.cp       = cp;
      beat.rep      = rep;
      beat.run_end  = 1'b0;
      beat.text_end = 1'b0;
      fresh_q.push_back(beat);
    endfunction

    // Decodes a byte with no sequence open.
    function void start_char(logic [7:0] b, bit fin);
      bit opened;
      opened = 1'b1;
      if (b[7] == 1'b0) begin
        emit({{(CpW-8){1'b0}}, b}, 1'b0);
        opened = 1'b0;
      end else if (b[7:5] == 3'b110) begin
        pending = PendOne;
        partial = {{(CpW-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        pending = PendTwo;
        partial = {{(CpW-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        pending = PendThree;
        partial = {{(CpW-3){1'b0}}, b[2:0]};
      end else begin
        // Stray continuation byte or an invalid lead.
        emit(ReplCp, 1'b1);
        opened = 1'b0;
      end
      // A lead byte at the end of the buffer is a truncated sequence.
      if (opened && fin) begin
        pending = PendNone;
        partial = '0;
        emit(ReplCp, 1'b1);
      end
    endfunction

    function void note_byte(logic [7:0] b, bit fin);
      cp_beat_t last;
      fresh_q.delete();
      if (pending == PendNone) begin
        start_char(b, fin);
      end else if (b[7:6] == 2'b10) begin
        partial = {partial[CpW-7:0], b[5:0]};
        pending = pending - 2'd1;
        if (pending == PendNone) begin
          emit(partial, 1'b0);
          partial = '0;
        end else if (fin) begin
          emit(ReplCp, 1'b1);
        end
      end else begin
        // The open sequence is broken; the byte then starts over.
        pending = PendNone;
        partial = '0;
        emit(ReplCp, 1'b1);
        start_char(b, fin);
      end
      if (fin) begin
        pending = PendNone;
        partial = '0;
      end
      if (fresh_q.size() > 0) begin
        last          = fresh_q.pop_back();
        last.run_end  = 1'b1;
        last.text_end = fin;
        fresh_q.push_back(last);
      end
      foreach (fresh_q[k]) expected_q.push_back(fresh_q[k]);
    endfunction

    function void check_beat(logic [OutDataW-1:0] data, logic [1:0] user, logic last);
      cp_beat_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("ERROR: beat with nothing expected: cp=%h rep=%b run_end=%b text_end=%b",
                   data, user[0], user[1], last);
      end else begin
        want = expected_q.pop_front();
        if (data !== {{(OutDataW-CpW){1'b0}}, want.cp} || user[0] !== want.rep ||
            user[1] !== want.run_end || last !== want.text_end) begin
          mismatches++;
          if (mismatches <= ShownErrors)
            $display("ERROR: expected cp=%h rep=%b run_end=%b text_end=%b, got cp=%h rep=%b run_end=%b text_end=%b",
                     want.cp, want.rep, want.run_end, want.text_end,
                     data, user[0], user[1], last);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] data_byte
  logic                s_axis_tlast;   // final_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [20:0] code_point, [23:21] zero
  logic [1:0]          m_axis_tuser;   // [0] replaced, [1] run_end
  logic                m_axis_tlast;   // text_end

  utf8_scoreboard sb = new();
  int unsigned    bytes_sent;
  int unsigned    stuck_cycles;
  bit             quiet;
  bit             hold_request;

  utf8_code_point_decoder_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Watchdog on cycles in which no beat moves on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("utf8_code_point_decoder_core test failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        for (int k = 0; k < HoldCycles; k++) begin
          m_axis_tready <= 1'b0;
          @(negedge clk_i);
        end
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= GapPercent);
    end
  end

  // Offers one byte, starting and ending at a falling edge.
  task automatic send_byte(input logic [7:0] b, input bit fin);
    while (!quiet && $urandom_range(99) < GapPercent) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
    if (bytes_sent == HoldAt) hold_request = 1'b1;
    @(negedge clk_i);
  endtask

  // Stops offering bytes until every expected code point has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  function automatic bit pick_final();
    return $urandom_range(29) == 0;
  endfunction

  // Sends one character: mostly well-formed, sometimes cut short or noise.
  task automatic send_char();
    int unsigned kind;
    int unsigned n_cont;
    logic [7:0]  lead;
    kind = $urandom_range(99);
    if (kind < 28) begin
      lead   = 8'($urandom_range(8'h7F, 8'h00));
      n_cont = 0;
    end else if (kind < 48) begin
      lead   = 8'($urandom_range(8'hDF, 8'hC0));
      n_cont = 1;
    end else if (kind < 64) begin
      lead   = 8'($urandom_range(8'hEF, 8'hE0));
      n_cont = 2;
    end else if (kind < 78) begin
      lead   = 8'($urandom_range(8'hF7, 8'hF0));
      n_cont = 3;
    end else if (kind < 88) begin
      // Possibly truncated sequence, interrupted by whatever follows.
      lead   = 8'($urandom_range(8'hFF, 8'hC0));
      n_cont = $urandom_range(2);
    end else begin
      lead   = 8'($urandom_range(8'hFF, 8'h00));
      n_cont = 0;
    end
    send_byte(lead, pick_final());
    for (int k = 0; k < n_cont; k++)
      send_byte(8'($urandom_range(8'hBF, 8'h80)), pick_final());
  endtask

  // Main stimulus.
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    quiet         = 1'b0;
    hold_request  = 1'b0;
    bytes_sent    = 0;
    stuck_cycles  = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: ASCII extremes, each sequence length, and the malformed cases.
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);   // stray continuation
    send_byte(8'hFF, 1'b0);   // invalid lead
    send_byte(8'hF8, 1'b0);   // invalid lead
    send_byte(8'hC3, 1'b0);
    send_byte(8'h41, 1'b0);   // breaks the sequence, then decodes as ASCII
    send_byte(8'hE2, 1'b1);   // lead at the end of the buffer
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);   // cut off after one continuation
    send_byte(8'hC3, 1'b0);
    send_byte(8'hE2, 1'b1);   // broken sequence and a truncated lead together
    send_byte(8'hEF, 1'b0);   // properly encoded replacement character
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBD, 1'b1);
    wait_drained();

    // Random characters; the sender pauses to drain around DrainAt and sends without gaps while quiet.
    while (bytes_sent < RandomBytes) begin
      quiet = (bytes_sent >= QuietFrom) && (bytes_sent < QuietTo);
      if (bytes_sent >= DrainAt && bytes_sent < DrainAt + 4) wait_drained();
      send_char();
    end
    quiet = 1'b0;
    wait_drained();
    repeat (TailCycles) @(negedge clk_i);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("utf8_code_point_decoder_core test passed");
    end else begin
      $display("utf8_code_point_decoder_core test failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/u8cpd_pkg.sv
hdl/u8cpd_front.sv
hdl/u8cpd_fifo.sv
hdl/u8cpd_back.sv
hdl/utf8_code_point_decoder_core.sv
hdl/u8cpd_checker.sv
tb/tb.sv
